FILE: hw/rtl/kfsd_pkg.sv
// Package holding the shared types and constants of the keyed FIFO set.
package kfsd_pkg;

  localparam int NumQueues = 16;
  localparam int Depth     = 16;
  localparam int IdBits    = 16;
  localparam int QBits     = 4;
  localparam int SlotBits  = 4;
  localparam int CntBits   = 5;
  localparam int AddrBits  = QBits + SlotBits;

  typedef enum logic [2:0] {
    ActEnq   = 3'd0,
    ActDeq   = 3'd1,
    ActRem   = 3'd2,
    ActQuery = 3'd3,
    ActList  = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    StOk    = 3'd0,
    StDup   = 3'd1,
    StEmpty = 3'd2,
    StNone  = 3'd3,
    StFull  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SShift,
    SList,
    SOut
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  queue_index;
    logic [15:0] member_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_id;
    logic [4:0]  position;
    logic [4:0]  queue_size;
    logic        last;
  } out_word_t;

endpackage

FILE: hw/rtl/keyed_fifo_set_with_dedup.sv
// Top level of the keyed FIFO set: sequencer around one entry memory.
// A word is accepted, starts the walk, takes one memory read per slot walked and then
// gives its result; remove scans to the match, then shifts the rest, and dequeue shifts
// the queue up behind its head.
// The output register lets the next word be accepted while a result waits.
// Reset clears the per-queue counts and the control state; the entry memory is not cleared.
module keyed_fifo_set_with_dedup (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kfsd_pkg::in_word_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kfsd_pkg::out_word_t  out_data_o
);
  import kfsd_pkg::*;

  state_e state_q, state_d;
  in_word_t req_q;
  logic [CntBits-1:0] n_q, idx_q, idx_d;
  logic [CntBits-1:0] cnt_q [NumQueues];
  logic [CntBits-1:0] pos_q, pos_d;
  logic rd_pend_q, rd_pend_d;
  logic [IdBits-1:0] mem [NumQueues*Depth];
  logic [IdBits-1:0] rdata_q, head_q, head_d;
  logic rd_en, wr_en;
  logic [AddrBits-1:0] rd_addr, wr_addr;
  logic [IdBits-1:0] wr_data;
  logic out_valid_q;
  out_word_t out_q, res;
  logic res_en, cnt_wr;
  logic [CntBits-1:0] cnt_new;
  logic accept, out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Entry memory with a registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (accept) begin
        state_d = SScan;
      end
      SScan: begin
        if (!rd_pend_q) begin
          unique case (req_q.action)
            ActDeq:  state_d = (n_q == '0) ? SOut : SShift;
            ActList: state_d = (n_q == '0) ? SOut : SList;
            ActEnq, ActRem, ActQuery: state_d = (n_q == '0) ? SOut : SScan;
            default: state_d = SOut;
          endcase
        end else if (rdata_q == req_q.member_id || idx_q == n_q) begin
          if (rdata_q == req_q.member_id && req_q.action == ActRem) state_d = SShift;
          else state_d = SOut;
        end
      end
      SShift: if (idx_q >= n_q && !rd_pend_q) state_d = SOut;
      SList:  if (out_free && rd_pend_q && idx_q == n_q) state_d = SIdle;
      SOut:   if (out_free) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    idx_d = idx_q; pos_d = pos_q; rd_pend_d = 1'b0; head_d = head_q;
    rd_en = 1'b0; rd_addr = {req_q.queue_index, idx_q[SlotBits-1:0]};
    wr_en = 1'b0; wr_addr = '0; wr_data = rdata_q;
    res_en = 1'b0; res = '0; cnt_wr = 1'b0; cnt_new = n_q;
    res.queue_size = n_q; res.last = 1'b1;
    unique case (state_q)
      SIdle: begin
        idx_d = '0; pos_d = '0;
      end
      SScan: begin
        if (!rd_pend_q) begin
          if (n_q != '0 && (req_q.action == ActEnq || req_q.action == ActRem ||
                            req_q.action == ActQuery || req_q.action == ActDeq ||
                            req_q.action == ActList)) begin
            rd_en = 1'b1; rd_pend_d = 1'b1; idx_d = idx_q + 1'b1;
          end
        end else if (rdata_q == req_q.member_id) begin
          pos_d = idx_q;
        end else if (idx_q != n_q) begin
          rd_en = 1'b1; rd_pend_d = 1'b1; idx_d = idx_q + 1'b1;
        end
        if (req_q.action == ActDeq && !rd_pend_q) pos_d = 5'd1;
      end
      SShift: begin
        // Each slot read beyond the removed one is written one place lower once its data returns.
        if (rd_pend_q) begin
          if (idx_q == pos_q && req_q.action == ActDeq && pos_q == 5'd1) head_d = rdata_q;
          if (idx_q > pos_q) begin
            wr_en = 1'b1;
            wr_addr = {req_q.queue_index, 4'(idx_q - 2'd2)};
          end
        end
        if (idx_q < n_q) begin
          rd_en = 1'b1; rd_pend_d = 1'b1; idx_d = idx_q + 1'b1;
        end else if (rd_pend_q && idx_q == pos_q) begin
          rd_pend_d = 1'b0;
        end
      end
      SList: begin
        if (!rd_pend_q) begin
          rd_en = 1'b1; rd_pend_d = 1'b1; idx_d = idx_q + 1'b1;
        end else begin
          rd_pend_d = 1'b1;
          res.out_id = rdata_q; res.position = idx_q;
          res.last = (idx_q == n_q);
          if (out_free) begin
            res_en = 1'b1;
            if (idx_q != n_q) begin
              rd_en = 1'b1; idx_d = idx_q + 1'b1;
            end
          end
        end
      end
      SOut: begin
        res_en = out_free;
        unique case (req_q.action)
          ActEnq: begin
            if (pos_q != '0) res.status = StDup;
            else if (n_q >= 5'(Depth)) res.status = StFull;
            else begin
              res.queue_size = n_q + 1'b1;
              if (out_free) begin
                wr_en = 1'b1; wr_addr = {req_q.queue_index, n_q[SlotBits-1:0]};
                wr_data = req_q.member_id; cnt_wr = 1'b1; cnt_new = n_q + 1'b1;
              end
            end
          end
          ActDeq: begin
            if (n_q == '0) res.status = StEmpty;
            else begin
              res.out_id = head_q; res.queue_size = n_q - 1'b1;
              cnt_wr = out_free; cnt_new = n_q - 1'b1;
            end
          end
          ActRem: begin
            if (pos_q == '0) res.status = StNone;
            else begin
              res.queue_size = n_q - 1'b1;
              cnt_wr = out_free; cnt_new = n_q - 1'b1;
            end
          end
          ActQuery: begin
            res.status = (pos_q == '0) ? StNone : StOk;
            res.position = pos_q;
          end
          ActList: res.status = StEmpty;
          default: res.status = StOk;
        endcase
      end
      default: ;
    endcase
  end

  // Control and payload registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rd_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumQueues; i++) cnt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      rd_pend_q <= rd_pend_d;
      if (res_en) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cnt_wr) cnt_q[req_q.queue_index] <= cnt_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
      n_q <= cnt_q[in_data_i.queue_index];
    end
    idx_q <= idx_d;
    pos_q <= pos_d;
    head_q <= head_d;
    if (res_en) out_q <= res;
  end

  // Checks on the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_wr |-> cnt_new <= 5'(Depth)) else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_en |-> out_free) else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == SScan) else $error("accept did not start scan");
endmodule

FILE: dv/keyed_fifo_set_with_dedup_test.sv
// Self-checking testbench for the keyed FIFO set with duplicate check.
module keyed_fifo_set_with_dedup_test;
  timeunit 1ns;
  timeprecision 1ps;
  import kfsd_pkg::*;

  localparam int ListCap = 16;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  keyed_fifo_set_with_dedup u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // Shadow copy of the queues used to work out the expected results.
  logic [IdBits-1:0]  shadow_ids [NumQueues][Depth];
  logic [CntBits-1:0] shadow_count [NumQueues];

  in_word_t  pending_words [$];
  out_word_t expected_words [$];
  int        error_count = 0;
  int        result_count = 0;
  int        words_sent = 0;
  int        words_total = 0;
  bit        hold_off = 1'b0;

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Appends an expected result to the tail of the check queue.
  function automatic void queue_result(out_word_t w);
    expected_words.insert(expected_words.size(), w);
  endfunction

  // Appends a word to the tail of the stimulus queue.
  function automatic void queue_word(in_word_t w);
    pending_words.insert(pending_words.size(), w);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR: result %0d field %s got %0d expected %0d", result_count, what, got,
             want);
    error_count++;
  endtask

  function automatic out_word_t make_word(status_e st, logic [15:0] id, int pos, int size,
                                          bit fin);
    out_word_t w;
    w.status = st;
    w.out_id = id;
    w.position = pos[4:0];
    w.queue_size = size[4:0];
    w.last = fin;
    return w;
  endfunction

  function automatic int find_slot(int q, logic [15:0] id);
    for (int i = 0; i < shadow_count[q]; i++) begin
      if (shadow_ids[q][i] == id) return i + 1;
    end
    return 0;
  endfunction

  // Applies one word to the shadow queues and queues its expected results.
  function automatic void predict_queue_op(in_word_t w);
    int q;
    int n;
    int pos;
    int cnt;
    logic [15:0] id;
    q = w.queue_index;
    id = w.member_id;
    n = shadow_count[q];
    case (w.action)
      ActEnq: begin
        if (find_slot(q, id) != 0) begin
          queue_result(make_word(StDup, '0, 0, n, 1'b1));
        end else if (n >= Depth) begin
          queue_result(make_word(StFull, '0, 0, n, 1'b1));
        end else begin
          shadow_ids[q][n] = id;
          shadow_count[q] = n + 1;
          queue_result(make_word(StOk, '0, 0, n + 1, 1'b1));
        end
      end
      ActDeq: begin
        if (n == 0) begin
          queue_result(make_word(StEmpty, '0, 0, 0, 1'b1));
        end else begin
          id = shadow_ids[q][0];
          for (int i = 1; i < n; i++) shadow_ids[q][i-1] = shadow_ids[q][i];
          shadow_count[q] = n - 1;
          queue_result(make_word(StOk, id, 0, n - 1, 1'b1));
        end
      end
      ActRem: begin
        pos = find_slot(q, id);
        if (pos == 0) begin
          queue_result(make_word(StNone, '0, 0, n, 1'b1));
        end else begin
          for (int i = pos; i < n; i++) shadow_ids[q][i-1] = shadow_ids[q][i];
          shadow_count[q] = n - 1;
          queue_result(make_word(StOk, '0, 0, n - 1, 1'b1));
        end
      end
      ActQuery: begin
        pos = find_slot(q, id);
        queue_result(make_word(pos != 0 ? StOk : StNone, '0, pos, n, 1'b1));
      end
      ActList: begin
        cnt = n < ListCap ? n : ListCap;
        if (cnt == 0) begin
          queue_result(make_word(StEmpty, '0, 0, 0, 1'b1));
        end else begin
          for (int i = 0; i < cnt; i++) begin
            queue_result(make_word(StOk, shadow_ids[q][i], i + 1, n, i + 1 == cnt));
          end
        end
      end
      default: begin
        // Undefined actions leave the queue alone and report its size.
        queue_result(make_word(StOk, '0, 0, n, 1'b1));
      end
    endcase
  endfunction

  function automatic in_word_t make_in(logic [2:0] act, int q, logic [15:0] id);
    in_word_t w;
    w.action = act;
    w.queue_index = q[3:0];
    w.member_id = id;
    return w;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(0, 3);
  endfunction

  // Sender: offers the next pending word after a random gap.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_queue_op(in_data_i);
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data_i <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each accepted result and stalls at random.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        result_count++;
        if (expected_words.size() == 0) begin
          $display("ERROR: unexpected result %0d", result_count);
          error_count++;
        end else begin
          want = expected_words.pop_front();
          if (out_data_o.status !== want.status)
            report_mismatch("status", out_data_o.status, want.status);
          if (out_data_o.out_id !== want.out_id)
            report_mismatch("out_id", out_data_o.out_id, want.out_id);
          if (out_data_o.position !== want.position)
            report_mismatch("position", out_data_o.position, want.position);
          if (out_data_o.queue_size !== want.queue_size)
            report_mismatch("queue_size", out_data_o.queue_size, want.queue_size);
          if (out_data_o.last !== want.last)
            report_mismatch("last", out_data_o.last, want.last);
        end
      end
      if (hold_off) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= pick_gap() == 0;
      end
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin
    wait (words_sent >= 40);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // Builds a run of random operations, mostly on queues 0 to 2, with random content and some undefined actions.
  task automatic add_random_words(int count);
    int q;
    logic [2:0] act;
    logic [15:0] id;
    for (int k = 0; k < count; k++) begin
      q = $urandom_range(0, 3) == 0 ? $urandom_range(0, NumQueues - 1) : $urandom_range(0, 2);
      // Small id pool so duplicates, hits and removals are frequent.
      id = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 20));
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: act = ActEnq;
        8, 9, 10:               act = ActDeq;
        11, 12, 13:             act = ActRem;
        14, 15, 16:             act = ActQuery;
        17, 18:                 act = ActList;
        default:                act = 3'($urandom_range(5, 7));
      endcase
      queue_word(make_in(act, q, id));
    end
  endtask

  initial begin
    foreach (shadow_count[i]) shadow_count[i] = '0;
    // Directed part: empty cases, id extremes, duplicate, undefined actions, fill to full, long list.
    queue_word(make_in(ActDeq, 15, 16'hFFFF));
    queue_word(make_in(ActList, 15, '0));
    queue_word(make_in(ActQuery, 15, 16'h0000));
    queue_word(make_in(ActRem, 15, 16'hFFFF));
    queue_word(make_in(ActEnq, 15, 16'hFFFF));
    queue_word(make_in(ActEnq, 15, 16'hFFFF));
    queue_word(make_in(ActEnq, 15, 16'h0000));
    queue_word(make_in(ActQuery, 15, 16'h0000));
    queue_word(make_in(3'd7, 15, 16'hAAAA));
    queue_word(make_in(3'd5, 0, 16'h5555));
    queue_word(make_in(ActDeq, 15, '0));
    queue_word(make_in(ActRem, 15, 16'h0000));
    for (int i = 0; i < Depth; i++) queue_word(make_in(ActEnq, 7, 16'(i * 4099)));
    queue_word(make_in(ActEnq, 7, 16'h1234));
    queue_word(make_in(ActList, 7, '0));
    queue_word(make_in(ActRem, 7, 16'(5 * 4099)));
    queue_word(make_in(ActQuery, 7, 16'(15 * 4099)));
    add_random_words(120);
    words_total = pending_words.size();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (words_sent == words_total);
    wait (expected_words.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d words and %0d results over all actions, including full, empty,",
             words_total, result_count);
    $display("duplicate, absent-id and undefined-action cases, with a long output stall.");
    if (error_count == 0 && expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
